// ===== rtl/sfab_pkg.sv =====
// ----------------------------------------------------------------------------
// sfab_pkg
// Shared types, widths and request codes of the sprite frame animator bank.
// ----------------------------------------------------------------------------
package sfab_pkg;

  // default table sizes
  localparam int DEF_PATTERN_SLOTS = 128;
  localparam int DEF_PLAYER_SLOTS  = 256;

  // field widths
  localparam int REQ_W    = 3;
  localparam int TEX_W    = 12;
  localparam int FRAMES_W = 9;
  localparam int PERIOD_W = 24;
  localparam int DIM_W    = 16;
  localparam int SLOT_W   = 8;
  localparam int FRAME_W  = 8;
  localparam int TIME_W   = 32;
  localparam int SRCX_W   = 24;

  // frame count limit of one pattern
  localparam logic [FRAMES_W-1:0] MAX_FRAMES = FRAMES_W'(256);

  // request codes
  localparam logic [REQ_W-1:0] REQ_REG_PATTERN = 3'd0;
  localparam logic [REQ_W-1:0] REQ_CREATE      = 3'd1;
  localparam logic [REQ_W-1:0] REQ_DESTROY     = 3'd2;
  localparam logic [REQ_W-1:0] REQ_TICK        = 3'd3;
  localparam logic [REQ_W-1:0] REQ_QUERY       = 3'd4;

  // one pattern table entry
  typedef struct packed {
    logic [TEX_W-1:0]    texture;
    logic [FRAMES_W-1:0] frames;
    logic [PERIOD_W-1:0] period;
    logic [DIM_W-1:0]    cell_w;
    logic [DIM_W-1:0]    cell_h;
    logic [DIM_W-1:0]    origin_x;
    logic [DIM_W-1:0]    origin_y;
    logic                loops;
  } pat_rec_t;

  // one result item
  typedef struct packed {
    logic              ok;
    logic [SLOT_W-1:0] slot_out;
    logic [TEX_W-1:0]  tex_out;
    logic [SRCX_W-1:0] src_x;
    logic [DIM_W-1:0]  src_y;
    logic [DIM_W-1:0]  src_w;
    logic [DIM_W-1:0]  src_h;
    logic              stopped_out;
  } res_t;

  // sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_PSCAN,
    S_CSCAN,
    S_TK_CHK,
    S_TK_PLR,
    S_TK_PAT,
    S_TK_ADD,
    S_QY_RD,
    S_QY_PLR,
    S_QY_PAT,
    S_QY_SUM,
    S_DONE
  } state_t;

endpackage

// ===== rtl/sfab_if.sv =====
// ----------------------------------------------------------------------------
// sfab_if
// Request and result channels of the sprite frame animator bank.
// ----------------------------------------------------------------------------
interface sfab_in_if;
  logic                           valid;
  logic                           ready;
  logic [sfab_pkg::REQ_W-1:0]     req_type;
  logic [sfab_pkg::TEX_W-1:0]     texture_id;
  logic [sfab_pkg::FRAMES_W-1:0]  frame_count;
  logic [sfab_pkg::PERIOD_W-1:0]  frame_period;
  logic [sfab_pkg::DIM_W-1:0]     cell_width;
  logic [sfab_pkg::DIM_W-1:0]     cell_height;
  logic [sfab_pkg::DIM_W-1:0]     start_x;
  logic [sfab_pkg::DIM_W-1:0]     start_y;
  logic                           looped;
  logic [sfab_pkg::SLOT_W-1:0]    slot_index;
  logic [sfab_pkg::PERIOD_W-1:0]  tick_us;

  modport source (
    output valid, req_type, texture_id, frame_count, frame_period, cell_width,
           cell_height, start_x, start_y, looped, slot_index, tick_us,
    input  ready
  );
  modport sink (
    input  valid, req_type, texture_id, frame_count, frame_period, cell_width,
           cell_height, start_x, start_y, looped, slot_index, tick_us,
    output ready
  );
endinterface

interface sfab_out_if;
  logic                         valid;
  logic                         ready;
  logic                         ok;
  logic [sfab_pkg::SLOT_W-1:0]  slot_out;
  logic [sfab_pkg::TEX_W-1:0]   tex_out;
  logic [sfab_pkg::SRCX_W-1:0]  src_x;
  logic [sfab_pkg::DIM_W-1:0]   src_y;
  logic [sfab_pkg::DIM_W-1:0]   src_w;
  logic [sfab_pkg::DIM_W-1:0]   src_h;
  logic                         stopped_out;

  modport source (
    output valid, ok, slot_out, tex_out, src_x, src_y, src_w, src_h, stopped_out,
    input  ready
  );
  modport sink (
    input  valid, ok, slot_out, tex_out, src_x, src_y, src_w, src_h, stopped_out,
    output ready
  );
endinterface

// ===== rtl/sfab_ram.sv =====
// ----------------------------------------------------------------------------
// sfab_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sfab_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/sprite_frame_animator_bank_core.sv =====
// ----------------------------------------------------------------------------
// sprite_frame_animator_bank_core
// Pattern and player tables for sprite-sheet animation, run by one sequencer.
// ----------------------------------------------------------------------------
// One request is taken at a time; in_chan.ready is high only while the
// sequencer is idle, and a finished result waits in the output register so the
// next request can enter. Register pattern and create player scan for a free
// slot, one slot scanned per cycle, and a tick visits every player slot in
// turn; each used player goes through read, pattern fetch, period compare and
// saturating add on the shared datapath, through the single player RAM read
// port. A finished result waits while the output register is still held by an
// unaccepted result. No clearing pass is needed after reset: used flags are
// flip-flops cleared at once.
module sprite_frame_animator_bank_core #(
  parameter int PATTERN_SLOTS = sfab_pkg::DEF_PATTERN_SLOTS,
  parameter int PLAYER_SLOTS  = sfab_pkg::DEF_PLAYER_SLOTS
) (
  input  logic       clk,
  input  logic       rst_n,
  sfab_in_if.sink    in_chan,
  sfab_out_if.source out_chan
);

  localparam int PAT_AW = PATTERN_SLOTS > 1 ? $clog2(PATTERN_SLOTS) : 1;
  localparam int PLR_AW = PLAYER_SLOTS > 1 ? $clog2(PLAYER_SLOTS) : 1;
  localparam int TW     = sfab_pkg::TIME_W;
  localparam int FW     = sfab_pkg::FRAME_W;
  // player entry: {pattern, frame, time, halted}
  localparam int PLR_W  = PAT_AW + FW + TW + 1;
  localparam int T_LO   = 1;
  localparam int F_LO   = TW + 1;
  localparam int P_LO   = TW + FW + 1;
  localparam logic [PAT_AW-1:0] PAT_LAST = PAT_AW'(PATTERN_SLOTS - 1);
  localparam logic [PLR_AW-1:0] PLR_LAST = PLR_AW'(PLAYER_SLOTS - 1);

  sfab_pkg::state_t   state_r, state_nxt;
  sfab_pkg::pat_rec_t new_pat_r, new_pat_nxt;
  sfab_pkg::pat_rec_t pat_r, pat_nxt;
  sfab_pkg::res_t     res_r, res_nxt;
  sfab_pkg::res_t     out_r, out_nxt;
  logic                           out_valid_r, out_valid_nxt;
  logic [sfab_pkg::SLOT_W-1:0]    slot_r, slot_nxt;
  logic [sfab_pkg::PERIOD_W-1:0]  elapsed_r, elapsed_nxt;
  logic [PAT_AW-1:0]              pat_idx_r, pat_idx_nxt;
  logic [PLR_AW-1:0]              plr_idx_r, plr_idx_nxt;
  logic [PAT_AW-1:0]              plr_pat_r, plr_pat_nxt;
  logic [FW-1:0]                  frame_r, frame_nxt;
  logic [TW-1:0]                  time_r, time_nxt;
  logic                           halted_r, halted_nxt;
  logic [sfab_pkg::SRCX_W-1:0]    prod_r, prod_nxt;
  logic [PATTERN_SLOTS-1:0]       pat_used_r, pat_used_nxt;
  logic [PLAYER_SLOTS-1:0]        plr_used_r, plr_used_nxt;

  // table ports
  logic                 pat_we;
  logic [PAT_AW-1:0]    pat_raddr;
  sfab_pkg::pat_rec_t   pat_rdata;
  logic                 plr_we;
  logic [PLR_AW-1:0]    plr_raddr;
  logic [PLR_W-1:0]     plr_wdata;
  logic [PLR_W-1:0]     plr_rdata;

  // request decode
  logic                           in_fire;
  logic                           crt_ok;
  logic                           plr_slot_ok;
  logic [sfab_pkg::FRAMES_W-1:0]  frames_clamped;
  logic                           last_pat;
  logic                           last_plr;
  logic                           out_free;

  // tick arithmetic
  logic                           per_ge;
  logic [sfab_pkg::FRAMES_W-1:0]  frame_inc;
  logic [TW:0]                    time_sum;

  assign in_fire  = in_chan.valid && in_chan.ready;
  assign crt_ok   = (32'(in_chan.slot_index) < 32'(PATTERN_SLOTS)) &&
                    pat_used_r[PAT_AW'(in_chan.slot_index)];
  assign plr_slot_ok = (32'(in_chan.slot_index) < 32'(PLAYER_SLOTS)) &&
                       plr_used_r[PLR_AW'(in_chan.slot_index)];
  assign last_pat = (pat_idx_r == PAT_LAST);
  assign last_plr = (plr_idx_r == PLR_LAST);
  assign out_free = !out_valid_r || out_chan.ready;

  // clamp frame count into one to the maximum
  always_comb begin
    priority if (in_chan.frame_count == '0) begin
      frames_clamped = sfab_pkg::FRAMES_W'(1);
    end else if (in_chan.frame_count > sfab_pkg::MAX_FRAMES) begin
      frames_clamped = sfab_pkg::MAX_FRAMES;
    end else begin
      frames_clamped = in_chan.frame_count;
    end
  end

  assign per_ge    = time_r >= TW'(pat_rdata.period);
  assign frame_inc = sfab_pkg::FRAMES_W'(frame_r) + sfab_pkg::FRAMES_W'(1);
  assign time_sum  = {1'b0, time_r} + (TW + 1)'(elapsed_r);

  // pattern table
  sfab_ram #(
    .WIDTH ($bits(sfab_pkg::pat_rec_t)),
    .DEPTH (PATTERN_SLOTS)
  ) u_pat_ram (
    .clk   (clk),
    .we    (pat_we),
    .waddr (pat_idx_r),
    .wdata (new_pat_r),
    .raddr (pat_raddr),
    .rdata (pat_rdata)
  );

  // player table
  sfab_ram #(
    .WIDTH (PLR_W),
    .DEPTH (PLAYER_SLOTS)
  ) u_plr_ram (
    .clk   (clk),
    .we    (plr_we),
    .waddr (plr_idx_r),
    .wdata (plr_wdata),
    .raddr (plr_raddr),
    .rdata (plr_rdata)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sfab_pkg::S_IDLE: begin
        if (in_fire) begin
          unique case (in_chan.req_type)
            sfab_pkg::REQ_REG_PATTERN: state_nxt = sfab_pkg::S_PSCAN;
            sfab_pkg::REQ_CREATE:
              state_nxt = crt_ok ? sfab_pkg::S_CSCAN : sfab_pkg::S_DONE;
            sfab_pkg::REQ_TICK:    state_nxt = sfab_pkg::S_TK_CHK;
            sfab_pkg::REQ_QUERY:
              state_nxt = plr_slot_ok ? sfab_pkg::S_QY_RD : sfab_pkg::S_DONE;
            default:               state_nxt = sfab_pkg::S_DONE;
          endcase
        end
      end
      sfab_pkg::S_PSCAN: begin
        if (!pat_used_r[pat_idx_r] || last_pat) state_nxt = sfab_pkg::S_DONE;
      end
      sfab_pkg::S_CSCAN: begin
        if (!plr_used_r[plr_idx_r] || last_plr) state_nxt = sfab_pkg::S_DONE;
      end
      sfab_pkg::S_TK_CHK: begin
        priority if (plr_used_r[plr_idx_r]) state_nxt = sfab_pkg::S_TK_PLR;
        else if (last_plr)                  state_nxt = sfab_pkg::S_DONE;
        else                                state_nxt = sfab_pkg::S_TK_CHK;
      end
      sfab_pkg::S_TK_PLR: state_nxt = sfab_pkg::S_TK_PAT;
      sfab_pkg::S_TK_PAT: state_nxt = sfab_pkg::S_TK_ADD;
      sfab_pkg::S_TK_ADD: state_nxt = last_plr ? sfab_pkg::S_DONE : sfab_pkg::S_TK_CHK;
      sfab_pkg::S_QY_RD:  state_nxt = sfab_pkg::S_QY_PLR;
      sfab_pkg::S_QY_PLR: state_nxt = sfab_pkg::S_QY_PAT;
      sfab_pkg::S_QY_PAT: state_nxt = sfab_pkg::S_QY_SUM;
      sfab_pkg::S_QY_SUM: state_nxt = sfab_pkg::S_DONE;
      sfab_pkg::S_DONE:   if (out_free) state_nxt = sfab_pkg::S_IDLE;
      default:            state_nxt = sfab_pkg::S_IDLE;
    endcase
  end

  // datapath and table controls
  always_comb begin
    new_pat_nxt   = new_pat_r;
    pat_nxt       = pat_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    slot_nxt      = slot_r;
    elapsed_nxt   = elapsed_r;
    pat_idx_nxt   = pat_idx_r;
    plr_idx_nxt   = plr_idx_r;
    plr_pat_nxt   = plr_pat_r;
    frame_nxt     = frame_r;
    time_nxt      = time_r;
    halted_nxt    = halted_r;
    prod_nxt      = prod_r;
    pat_used_nxt  = pat_used_r;
    plr_used_nxt  = plr_used_r;
    pat_we        = 1'b0;
    plr_we        = 1'b0;
    plr_raddr     = plr_idx_r;
    pat_raddr     = plr_rdata[P_LO +: PAT_AW];
    plr_wdata     = {plr_pat_r, frame_r, time_r, halted_r};

    unique case (state_r)
      // latch the item and settle destroy and rejected requests
      sfab_pkg::S_IDLE: begin
        if (in_fire) begin
          res_nxt              = '0;
          slot_nxt             = in_chan.slot_index;
          elapsed_nxt          = in_chan.tick_us;
          new_pat_nxt.texture  = in_chan.texture_id;
          new_pat_nxt.frames   = frames_clamped;
          new_pat_nxt.period   = in_chan.frame_period;
          new_pat_nxt.cell_w   = in_chan.cell_width;
          new_pat_nxt.cell_h   = in_chan.cell_height;
          new_pat_nxt.origin_x = in_chan.start_x;
          new_pat_nxt.origin_y = in_chan.start_y;
          new_pat_nxt.loops    = in_chan.looped;
          pat_idx_nxt          = '0;
          plr_idx_nxt          = '0;
          if (in_chan.req_type == sfab_pkg::REQ_DESTROY && plr_slot_ok) begin
            plr_used_nxt[PLR_AW'(in_chan.slot_index)] = 1'b0;
            res_nxt.ok = 1'b1;
          end
        end
      end
      // take the first free pattern slot
      sfab_pkg::S_PSCAN: begin
        if (!pat_used_r[pat_idx_r]) begin
          pat_we                  = 1'b1;
          pat_used_nxt[pat_idx_r] = 1'b1;
          res_nxt.ok              = 1'b1;
          res_nxt.slot_out        = sfab_pkg::SLOT_W'(pat_idx_r);
        end else if (!last_pat) begin
          pat_idx_nxt = pat_idx_r + PAT_AW'(1);
        end
      end
      // take the first free player slot
      sfab_pkg::S_CSCAN: begin
        plr_wdata = {PAT_AW'(slot_r), FW'(0), TW'(0), 1'b0};
        if (!plr_used_r[plr_idx_r]) begin
          plr_we                  = 1'b1;
          plr_used_nxt[plr_idx_r] = 1'b1;
          res_nxt.ok              = 1'b1;
          res_nxt.slot_out        = sfab_pkg::SLOT_W'(plr_idx_r);
        end else if (!last_plr) begin
          plr_idx_nxt = plr_idx_r + PLR_AW'(1);
        end
      end
      // skip unused players, read used ones
      sfab_pkg::S_TK_CHK: begin
        if (!plr_used_r[plr_idx_r]) begin
          if (last_plr) res_nxt.ok = 1'b1;
          else          plr_idx_nxt = plr_idx_r + PLR_AW'(1);
        end
      end
      // hold the player entry, fetch its pattern
      sfab_pkg::S_TK_PLR, sfab_pkg::S_QY_PLR: begin
        plr_pat_nxt = plr_rdata[P_LO +: PAT_AW];
        frame_nxt   = plr_rdata[F_LO +: FW];
        time_nxt    = plr_rdata[T_LO +: TW];
        halted_nxt  = plr_rdata[0];
      end
      // consume one period and step the frame
      sfab_pkg::S_TK_PAT: begin
        if (per_ge) begin
          time_nxt = time_r - TW'(pat_rdata.period);
          if (frame_inc >= pat_rdata.frames) begin
            if (pat_rdata.loops) begin
              frame_nxt = '0;
            end else begin
              frame_nxt  = FW'(pat_rdata.frames - sfab_pkg::FRAMES_W'(1));
              halted_nxt = 1'b1;
            end
          end else begin
            frame_nxt = FW'(frame_inc);
          end
        end
      end
      // add the tick time, saturating, and write back
      sfab_pkg::S_TK_ADD: begin
        plr_we    = 1'b1;
        plr_wdata = {plr_pat_r, frame_r, time_sum[TW] ? {TW{1'b1}} : time_sum[TW-1:0],
                     halted_r};
        if (last_plr) res_nxt.ok = 1'b1;
        else          plr_idx_nxt = plr_idx_r + PLR_AW'(1);
      end
      sfab_pkg::S_QY_RD: begin
        plr_raddr = PLR_AW'(slot_r);
      end
      // frame offset into the sheet
      sfab_pkg::S_QY_PAT: begin
        pat_nxt  = pat_rdata;
        prod_nxt = sfab_pkg::SRCX_W'(pat_rdata.cell_w) * sfab_pkg::SRCX_W'(frame_r);
      end
      sfab_pkg::S_QY_SUM: begin
        res_nxt.ok          = 1'b1;
        res_nxt.tex_out     = pat_r.texture;
        res_nxt.src_x       = sfab_pkg::SRCX_W'(pat_r.origin_x) + prod_r;
        res_nxt.src_y       = pat_r.origin_y;
        res_nxt.src_w       = pat_r.cell_w;
        res_nxt.src_h       = pat_r.cell_h;
        res_nxt.stopped_out = halted_r;
      end
      // hand the result to the output register
      sfab_pkg::S_DONE: begin
        if (out_free) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
        res_nxt = res_r;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sfab_pkg::S_IDLE;
      out_valid_r <= 1'b0;
      pat_used_r  <= '0;
      plr_used_r  <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      pat_used_r  <= pat_used_nxt;
      plr_used_r  <= plr_used_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    new_pat_r <= new_pat_nxt;
    pat_r     <= pat_nxt;
    res_r     <= res_nxt;
    out_r     <= out_nxt;
    slot_r    <= slot_nxt;
    elapsed_r <= elapsed_nxt;
    pat_idx_r <= pat_idx_nxt;
    plr_idx_r <= plr_idx_nxt;
    plr_pat_r <= plr_pat_nxt;
    frame_r   <= frame_nxt;
    time_r    <= time_nxt;
    halted_r  <= halted_nxt;
    prod_r    <= prod_nxt;
  end

  // ports
  assign in_chan.ready        = (state_r == sfab_pkg::S_IDLE);
  assign out_chan.valid       = out_valid_r;
  assign out_chan.ok          = out_r.ok;
  assign out_chan.slot_out    = out_r.slot_out;
  assign out_chan.tex_out     = out_r.tex_out;
  assign out_chan.src_x       = out_r.src_x;
  assign out_chan.src_y       = out_r.src_y;
  assign out_chan.src_w       = out_r.src_w;
  assign out_chan.src_h       = out_r.src_h;
  assign out_chan.stopped_out = out_r.stopped_out;

  // the sequencer is busy in the cycle after an accepted item
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_chan.ready)
    else $error("request taken while previous one still in work");

  // player table is written only by create or tick write-back
  a_plr_write_state: assert property (@(posedge clk) disable iff (!rst_n)
    plr_we |-> (state_r == sfab_pkg::S_TK_ADD || state_r == sfab_pkg::S_CSCAN))
    else $error("player table written outside create or tick");

  // tick write-back only touches used players
  a_tick_used: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == sfab_pkg::S_TK_ADD |-> plr_used_r[plr_idx_r])
    else $error("tick updated an unused player");

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for sprite_frame_animator_bank_core: drives requests
// through the input channel, predicts every result from its own copy of the
// pattern and player tables, and compares each result item field by field.
// ----------------------------------------------------------------------------
module tb;
  import sfab_pkg::*;

  localparam int NPAT       = DEF_PATTERN_SLOTS;
  localparam int NPLR       = DEF_PLAYER_SLOTS;
  localparam int CYCLE_CAP  = 20000000;
  localparam int RAND_ITEMS = 700;
  localparam logic [REQ_W-1:0] REQ_BAD_LO = 3'd5;
  localparam logic [REQ_W-1:0] REQ_BAD_HI = 3'd7;

  typedef struct packed {
    logic [REQ_W-1:0]    req;
    logic [TEX_W-1:0]    tex;
    logic [FRAMES_W-1:0] frames;
    logic [PERIOD_W-1:0] period;
    logic [DIM_W-1:0]    cw;
    logic [DIM_W-1:0]    ch;
    logic [DIM_W-1:0]    sx;
    logic [DIM_W-1:0]    sy;
    logic                loops;
    logic [SLOT_W-1:0]   slot;
    logic [PERIOD_W-1:0] elapsed;
  } anim_req_t;

  localparam int REQ_BITS = $bits(anim_req_t);

  logic clk;
  logic rst_n;
  sfab_in_if  in_bus ();
  sfab_out_if out_bus ();

  sprite_frame_animator_bank_core DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_bus),
    .out_chan(out_bus)
  );

  // shadow tables of the bank
  pat_rec_t            pat_tab   [NPAT];
  logic                pat_busy  [NPAT];
  logic [6:0]          plr_pat   [NPLR];
  logic [FRAME_W-1:0]  plr_frame [NPLR];
  logic [TIME_W-1:0]   plr_time  [NPLR];
  logic                plr_halt  [NPLR];
  logic                plr_busy  [NPLR];

  res_t pending_res[$];
  int   errors;
  int   cycles;
  int   burst_left;
  logic [15:0] stall_mask;
  int   stall_cnt;

  // clock
  always begin
    clk = 1'b1; #4;
    clk = 1'b0; #4;
  end

  // cycle limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_CAP) begin
      $display("FAIL");
      $finish;
    end
  end

  // receiver stall pattern: a rotating mask, reloaded when its counter runs out, sometimes with no stalls
  always @(negedge clk) begin
    if (stall_cnt == 0) begin
      stall_mask = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom);
      stall_cnt  = 64;
    end
    stall_cnt--;
    stall_mask     = {stall_mask[14:0], stall_mask[15]};
    out_bus.ready <= stall_mask[0] | ($urandom_range(0, 1) == 1);
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  function automatic int pat_count();
    int n = 0;
    for (int i = 0; i < NPAT; i++) n += pat_busy[i];
    return n;
  endfunction

  function automatic int plr_count();
    int n = 0;
    for (int i = 0; i < NPLR; i++) n += plr_busy[i];
    return n;
  endfunction

  function automatic void tick_player(int p, logic [PERIOD_W-1:0] el);
    pat_rec_t    pr;
    logic [8:0]  nxt;
    logic [32:0] sum;
    pr = pat_tab[plr_pat[p]];
    if (plr_time[p] >= TIME_W'(pr.period)) begin
      nxt = 9'(plr_frame[p]) + 9'd1;
      if (nxt >= pr.frames) begin
        if (pr.loops) nxt = '0;
        else begin
          nxt = pr.frames - 9'd1;
          plr_halt[p] = 1'b1;
        end
      end
      plr_frame[p] = nxt[7:0];
      plr_time[p]  = plr_time[p] - TIME_W'(pr.period);
    end
    sum = 33'(plr_time[p]) + 33'(el);
    plr_time[p] = sum[32] ? '1 : sum[31:0];
  endfunction

  // apply one request to the shadow tables and return its result item
  function automatic res_t animate_step(anim_req_t r);
    res_t        res;
    pat_rec_t    pr;
    logic [8:0]  fc;
    int          s;
    res = '0;
    s   = int'(r.slot);
    case (r.req)
      REQ_REG_PATTERN: begin
        fc = (r.frames == 0) ? 9'd1 : (r.frames > MAX_FRAMES ? MAX_FRAMES : r.frames);
        for (int i = 0; i < NPAT; i++) begin
          if (!pat_busy[i]) begin
            pat_busy[i] = 1'b1;
            pat_tab[i]  = '{texture: r.tex, frames: fc, period: r.period, cell_w: r.cw,
                            cell_h: r.ch, origin_x: r.sx, origin_y: r.sy, loops: r.loops};
            res.ok       = 1'b1;
            res.slot_out = SLOT_W'(i);
            break;
          end
        end
      end
      REQ_CREATE: begin
        if (s < NPAT && pat_busy[s]) begin
          for (int i = 0; i < NPLR; i++) begin
            if (!plr_busy[i]) begin
              plr_busy[i]  = 1'b1;
              plr_pat[i]   = 7'(s);
              plr_frame[i] = '0;
              plr_time[i]  = '0;
              plr_halt[i]  = 1'b0;
              res.ok       = 1'b1;
              res.slot_out = SLOT_W'(i);
              break;
            end
          end
        end
      end
      REQ_DESTROY: begin
        if (plr_busy[s]) begin
          plr_busy[s] = 1'b0;
          res.ok      = 1'b1;
        end
      end
      REQ_TICK: begin
        for (int i = 0; i < NPLR; i++)
          if (plr_busy[i]) tick_player(i, r.elapsed);
        res.ok = 1'b1;
      end
      REQ_QUERY: begin
        if (plr_busy[s]) begin
          pr = pat_tab[plr_pat[s]];
          res.ok          = 1'b1;
          res.tex_out     = pr.texture;
          res.src_x       = SRCX_W'(32'(pr.origin_x) + 32'(pr.cell_w) * 32'(plr_frame[s]));
          res.src_y       = pr.origin_y;
          res.src_w       = pr.cell_w;
          res.src_h       = pr.cell_h;
          res.stopped_out = plr_halt[s];
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Result checker
  // ---------------------------------------------------------------------------
  task automatic cmp_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t mismatch %s: expected %0h, actual %0h", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    res_t e;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (pending_res.size() == 0) begin
        $display("%0t unexpected result item: expected none, actual ok=%0b slot=%0h",
                 $time, out_bus.ok, out_bus.slot_out);
        errors++;
      end else begin
        e = pending_res.pop_front();
        cmp_field("ok",          e.ok,          out_bus.ok);
        cmp_field("slot_out",    e.slot_out,    out_bus.slot_out);
        cmp_field("tex_out",     e.tex_out,     out_bus.tex_out);
        cmp_field("src_x",       e.src_x,       out_bus.src_x);
        cmp_field("src_y",       e.src_y,       out_bus.src_y);
        cmp_field("src_w",       e.src_w,       out_bus.src_w);
        cmp_field("src_h",       e.src_h,       out_bus.src_h);
        cmp_field("stopped_out", e.stopped_out, out_bus.stopped_out);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sender: called and returning at a falling edge
  // ---------------------------------------------------------------------------
  task automatic send(anim_req_t r);
    int gap;
    in_bus.valid        <= 1'b1;
    in_bus.req_type     <= r.req;
    in_bus.texture_id   <= r.tex;
    in_bus.frame_count  <= r.frames;
    in_bus.frame_period <= r.period;
    in_bus.cell_width   <= r.cw;
    in_bus.cell_height  <= r.ch;
    in_bus.start_x      <= r.sx;
    in_bus.start_y      <= r.sy;
    in_bus.looped       <= r.loops;
    in_bus.slot_index   <= r.slot;
    in_bus.tick_us      <= r.elapsed;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    pending_res.push_back(animate_step(r));
    @(negedge clk);
    // bursts of random length separated by random gaps
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 30);
      gap        = $urandom_range(1, 6);
      in_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // hold the sender until every result is back
  task automatic drain();
    in_bus.valid <= 1'b0;
    @(negedge clk);
    while (pending_res.size() != 0) @(negedge clk);
  endtask

  function automatic anim_req_t mk(logic [REQ_W-1:0] req, logic [SLOT_W-1:0] slot);
    anim_req_t r;
    r = anim_req_t'(REQ_BITS'({$urandom, $urandom, $urandom, $urandom, $urandom,
                               $urandom}));
    r.req  = req;
    r.slot = slot;
    return r;
  endfunction

  function automatic anim_req_t mk_pat(logic [FRAMES_W-1:0] fr, logic [PERIOD_W-1:0] per,
                                       logic lp);
    anim_req_t r;
    r = mk(REQ_REG_PATTERN, '0);
    r.frames = fr;
    r.period = per;
    r.loops  = lp;
    return r;
  endfunction

  function automatic anim_req_t mk_tick(logic [PERIOD_W-1:0] el);
    anim_req_t r;
    r = mk(REQ_TICK, '0);
    r.elapsed = el;
    return r;
  endfunction

  function automatic logic [REQ_W-1:0] bad_req();
    return REQ_W'($urandom_range(REQ_BAD_LO, REQ_BAD_HI));
  endfunction

  function automatic int pick_busy_player();
    int p;
    for (int k = 0; k < 64; k++) begin
      p = $urandom_range(0, NPLR - 1);
      if (plr_busy[p]) return p;
    end
    for (int i = 0; i < NPLR; i++) if (plr_busy[i]) return i;
    return $urandom_range(0, NPLR - 1);
  endfunction

  function automatic int pick_busy_pattern();
    int n;
    n = pat_count();
    if (n == 0) return $urandom_range(0, 255);
    return $urandom_range(0, n - 1);   // patterns fill from the bottom
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_directed();
    anim_req_t r;
    // extremes of the pattern fields and frame-count clamping
    r = mk_pat(9'd0, 24'd1, 1'b0);
    r.tex = '1; r.cw = '1; r.ch = '1; r.sx = '1; r.sy = '1;
    send(r);
    r = mk_pat(9'd256, '1, 1'b1);
    r.tex = '0; r.cw = '0; r.ch = '0; r.sx = '0; r.sy = '0;
    send(r);
    send(mk_pat(9'd511, 24'd0, 1'b1));
    send(mk_pat(9'd2, 24'd0, 1'b0));
    // create on good, unused and out-of-table patterns
    send(mk(REQ_CREATE, 8'd0));
    send(mk(REQ_CREATE, 8'd2));
    send(mk(REQ_CREATE, 8'd3));
    send(mk(REQ_CREATE, 8'd127));
    send(mk(REQ_CREATE, 8'd255));
    send(mk(REQ_CREATE, 8'd200));
    // ticks at the elapsed extremes
    send(mk_tick(24'd0));
    send(mk_tick('1));
    send(mk_tick(24'd5));
    send(mk_tick('1));
    // queries: used players and the top index
    send(mk(REQ_QUERY, 8'd0));
    send(mk(REQ_QUERY, 8'd1));
    send(mk(REQ_QUERY, 8'd2));
    send(mk(REQ_QUERY, 8'd255));
    // destroy used, then again unused, then query the freed player
    send(mk(REQ_DESTROY, 8'd1));
    send(mk(REQ_DESTROY, 8'd1));
    send(mk(REQ_DESTROY, 8'd255));
    send(mk(REQ_QUERY, 8'd1));
    // unknown request codes
    for (logic [REQ_W-1:0] q = REQ_BAD_LO; q <= REQ_BAD_LO + 3'd1; q++) send(mk(q, '1));
    send(mk(REQ_BAD_HI, '0));
    drain();
  endtask

  // zero-period player gathers time until it saturates
  task automatic test_time_saturation();
    anim_req_t r;
    r = mk_pat(9'd3, 24'd0, 1'b1);
    send(r);
    send(mk(REQ_CREATE, SLOT_W'(pat_count() - 1)));
    drain();
    repeat (260) send(mk_tick('1));
    for (int i = 0; i < NPLR; i++) if (plr_busy[i]) send(mk(REQ_QUERY, SLOT_W'(i)));
    drain();
  endtask

  task automatic test_random();
    anim_req_t r;
    int sel;
    for (int n = 0; n < RAND_ITEMS; n++) begin
      sel = $urandom_range(0, 99);
      if (sel < 10) begin
        r = mk(REQ_REG_PATTERN, '0);
        if ($urandom_range(0, 3) != 0) begin
          r.frames = FRAMES_W'($urandom_range(1, 8));
          r.period = PERIOD_W'($urandom_range(0, 1500));
        end
      end else if (sel < 30) begin
        r = mk(REQ_CREATE, ($urandom_range(0, 7) == 0) ? SLOT_W'($urandom)
                                                       : SLOT_W'(pick_busy_pattern()));
      end else if (sel < 42) begin
        r = mk(REQ_DESTROY, ($urandom_range(0, 5) == 0) ? SLOT_W'($urandom)
                                                        : SLOT_W'(pick_busy_player()));
      end else if (sel < 57) begin
        r = mk(REQ_TICK, '0);
        if ($urandom_range(0, 4) != 0) r.elapsed = PERIOD_W'($urandom_range(0, 2000));
      end else if (sel < 97) begin
        r = mk(REQ_QUERY, ($urandom_range(0, 7) == 0) ? SLOT_W'($urandom)
                                                      : SLOT_W'(pick_busy_player()));
      end else begin
        r = mk(bad_req(), '0);
      end
      send(r);
      if (n == RAND_ITEMS / 2) drain();
    end
    drain();
  endtask

  // fill both tables, then ask once more for each
  task automatic test_tables_full();
    while (pat_count() < NPAT) send(mk_pat(9'd4, 24'd10, 1'b0));
    send(mk_pat(9'd4, 24'd10, 1'b1));
    while (plr_count() < NPLR) send(mk(REQ_CREATE, SLOT_W'(pick_busy_pattern())));
    send(mk(REQ_CREATE, 8'd0));
    repeat (3) send(mk_tick(24'd20));
    repeat (20) send(mk(REQ_QUERY, SLOT_W'($urandom)));
    drain();
  endtask

  initial begin
    errors       = 0;
    cycles       = 0;
    burst_left   = 0;
    stall_cnt    = 0;
    stall_mask   = '1;
    rst_n        = 1'b0;
    in_bus.valid = 1'b0;
    {in_bus.req_type, in_bus.texture_id, in_bus.frame_count, in_bus.frame_period,
     in_bus.cell_width, in_bus.cell_height, in_bus.start_x, in_bus.start_y,
     in_bus.looped, in_bus.slot_index, in_bus.tick_us} = '0;
    out_bus.ready = 1'b0;
    for (int i = 0; i < NPAT; i++) begin
      pat_busy[i] = 1'b0;
      pat_tab[i]  = '0;
    end
    for (int i = 0; i < NPLR; i++) begin
      plr_busy[i]  = 1'b0;
      plr_pat[i]   = '0;
      plr_frame[i] = '0;
      plr_time[i]  = '0;
      plr_halt[i]  = 1'b0;
    end
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_directed();
    test_time_saturation();
    test_random();
    test_tables_full();

    // let trailing activity settle
    repeat (1100) @(posedge clk);
    if (errors == 0 && pending_res.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
